>>> rtl/bpdc_pkg.sv
package bpdc_pkg;

	localparam int SETTLE_W   = 8;
	localparam int LONG_W     = 10;
	localparam int CFG_DATA_W = 10;
	localparam int COUNT_W    = 36;

	localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd2;
	localparam logic [LONG_W-1:0]   LONG_RESET   = 10'd200;

	typedef logic [0:0] cfg_index_t;

	localparam cfg_index_t CFG_SETTLE = 1'b0;
	localparam cfg_index_t CFG_LONG   = 1'b1;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2
	} press_event_t;

	typedef enum logic [2:0] {
		PH_IDLE         = 3'd0,
		PH_SETTLE_IN    = 3'd1,
		PH_HOLD         = 3'd2,
		PH_WAIT_RELEASE = 3'd3,
		PH_SETTLE_OUT   = 3'd4
	} phase_t;

endpackage

>>> rtl/bpdc_if.sv
interface bpdc_in_if;
	logic valid;
	logic ready;
	logic button_low;

	modport source (output valid, output button_low, input ready);
	modport sink (input valid, input button_low, output ready);
endinterface

interface bpdc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  press_event;
	logic [35:0] bcd_count;

	modport source (output valid, output press_event, output bcd_count, input ready);
	modport sink (input valid, input press_event, input bcd_count, output ready);
endinterface

>>> rtl/bpdc_core.sv
module bpdc_core
	import bpdc_pkg::*;
#(
	parameter int DIGITS = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  pressed,
	input  logic [SETTLE_W-1:0]   settle_ticks,
	input  logic [LONG_W-1:0]     long_ticks,
	output press_event_t          press_event,
	output logic [4*DIGITS-1:0]   bcd_next
);

	localparam int BW = 4 * DIGITS;

	phase_t              phase_q, phase_d;
	logic [LONG_W-1:0]   timer_q, timer_d;
	press_event_t        pending_q, pending_d;
	logic [BW-1:0]       bcd_q;
	logic [BW-1:0]       bcd_inc;
	logic [DIGITS:0]     carry;
	logic [LONG_W-1:0]   timer_inc;
	logic                settle_zero;
	logic                settle_done;
	logic                long_done;

	assign timer_inc   = timer_q + 10'd1;
	assign settle_zero = (settle_ticks == '0);
	assign settle_done = (timer_inc >= {2'b00, settle_ticks});
	assign long_done   = (timer_inc >= long_ticks);

	// A digit steps only when every lower digit rolls over; a digit above nine rolls like nine.
	always_comb begin
		carry[0] = 1'b1;
		for (int i = 0; i < DIGITS; i++) begin
			carry[i+1] = carry[i] && (bcd_q[4*i +: 4] >= 4'd9);
			if (!carry[i]) begin
				bcd_inc[4*i +: 4] = bcd_q[4*i +: 4];
			end else if (bcd_q[4*i +: 4] >= 4'd9) begin
				bcd_inc[4*i +: 4] = 4'd0;
			end else begin
				bcd_inc[4*i +: 4] = bcd_q[4*i +: 4] + 4'd1;
			end
		end
	end

	always_comb begin
		phase_d   = phase_q;
		timer_d   = timer_q;
		pending_d = pending_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (pressed) begin
					timer_d = '0;
					phase_d = settle_zero ? PH_HOLD : PH_SETTLE_IN;
				end
			end
			PH_SETTLE_IN: begin
				timer_d = timer_inc;
				if (settle_done) begin
					timer_d = '0;
					phase_d = PH_HOLD;
				end
			end
			PH_HOLD: begin
				if (!pressed) begin
					timer_d   = '0;
					pending_d = settle_zero ? EV_NONE : EV_SHORT;
					phase_d   = settle_zero ? PH_IDLE : PH_SETTLE_OUT;
				end else begin
					timer_d = timer_inc;
					if (long_done) begin
						timer_d = '0;
						phase_d = PH_WAIT_RELEASE;
					end
				end
			end
			PH_WAIT_RELEASE: begin
				if (!pressed) begin
					timer_d   = '0;
					pending_d = settle_zero ? EV_NONE : EV_LONG;
					phase_d   = settle_zero ? PH_IDLE : PH_SETTLE_OUT;
				end
			end
			PH_SETTLE_OUT: begin
				timer_d = timer_inc;
				if (settle_done) begin
					timer_d   = '0;
					pending_d = EV_NONE;
					phase_d   = PH_IDLE;
				end
			end
			default: begin
				timer_d   = '0;
				pending_d = EV_NONE;
				phase_d   = PH_IDLE;
			end
		endcase
	end

	always_comb begin
		press_event = EV_NONE;
		unique case (phase_q)
			PH_HOLD: begin
				if (!pressed && settle_zero) begin
					press_event = EV_SHORT;
				end
			end
			PH_WAIT_RELEASE: begin
				if (!pressed && settle_zero) begin
					press_event = EV_LONG;
				end
			end
			PH_SETTLE_OUT: begin
				if (settle_done) begin
					press_event = pending_q;
				end
			end
			default: begin
				press_event = EV_NONE;
			end
		endcase
	end

	always_comb begin
		case (press_event)
			EV_SHORT: bcd_next = bcd_inc;
			EV_LONG:  bcd_next = '0;
			default:  bcd_next = bcd_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			timer_q   <= '0;
			pending_q <= EV_NONE;
			bcd_q     <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			pending_q <= pending_d;
			bcd_q     <= bcd_next;
		end
	end

endmodule

>>> rtl/button_press_decimal_counter_unit.sv
// A sample transaction passes through the input register and then the result register.
// Throughput: one sample per cycle while the skid entry is empty; a two-entry result
// buffer absorbs a stalled output.
// Reset clears the press state, the counter and all valid flags, and loads the
// settle and long limits with 2 and 200 ticks.
module button_press_decimal_counter_unit
	import bpdc_pkg::*;
#(
	parameter int DIGITS = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bpdc_in_if.sink               sample,
	bpdc_out_if.source            result,
	input  logic                  cfg_we,
	input  cfg_index_t            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int BW = 4 * DIGITS;

	logic [SETTLE_W-1:0] settle_q;
	logic [LONG_W-1:0]   long_q;

	logic                v_s1;
	logic                button_s1;

	logic                out_valid_q;
	press_event_t        out_event_q;
	logic [COUNT_W-1:0]  out_bcd_q;
	logic                skid_valid_q;
	press_event_t        skid_event_q;
	logic [COUNT_W-1:0]  skid_bcd_q;

	logic                accept;
	logic                advance;
	logic                out_take;
	logic                to_out;
	press_event_t        core_event;
	logic [BW-1:0]       core_bcd;
	logic [BW+COUNT_W-1:0] bcd_ext;
	logic [COUNT_W-1:0]  new_bcd;

	assign accept   = sample.valid && sample.ready;
	assign advance  = v_s1 && !skid_valid_q;
	assign out_take = out_valid_q && result.ready;
	assign to_out   = !out_valid_q || out_take;

	assign sample.ready = !v_s1 || !skid_valid_q;

	assign bcd_ext = {{COUNT_W{1'b0}}, core_bcd};
	assign new_bcd = bcd_ext[COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_RESET;
			long_q   <= LONG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SETTLE: settle_q <= cfg_data[SETTLE_W-1:0];
				CFG_LONG:   long_q   <= cfg_data[LONG_W-1:0];
				default:    settle_q <= settle_q;
			endcase
		end
	end

	bpdc_core #(
		.DIGITS(DIGITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.pressed      (button_s1),
		.settle_ticks (settle_q),
		.long_ticks   (long_q),
		.press_event  (core_event),
		.bcd_next     (core_bcd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			button_s1 <= sample.button_low;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				if (to_out) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (to_out) begin
				out_event_q <= core_event;
				out_bcd_q   <= new_bcd;
			end else begin
				skid_event_q <= core_event;
				skid_bcd_q   <= new_bcd;
			end
		end else if (out_take && skid_valid_q) begin
			out_event_q <= skid_event_q;
			out_bcd_q   <= skid_bcd_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.press_event = out_event_q;
	assign result.bcd_count   = out_bcd_q;

`ifndef ASSERT_OFF
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("Skid entry holds a result while the output register is empty.");

	a_long_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.press_event == EV_LONG) |-> (result.bcd_count == '0))
		else $error("A long press result carries a nonzero count.");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("An accepted transaction did not reach the input register.");

	a_no_event_while_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !to_out) |-> !skid_valid_q)
		else $error("A result was written over a full skid entry.");
`endif

endmodule

>>> dv/button_press_decimal_counter_unit_tb.sv
module button_press_decimal_counter_unit_tb;
	import bpdc_pkg::*;

	localparam int CNT_DIGITS = 9;

	typedef struct packed {
		press_event_t         ev;
		logic [COUNT_W-1:0]   count;
	} tick_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bpdc_in_if  sample_if ();
	bpdc_out_if result_if ();

	button_press_decimal_counter_unit #(
		.DIGITS(CNT_DIGITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_if),
		.result   (result_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Shadow copy of the press detector and its limits.
	logic [SETTLE_W-1:0] settle_lim = SETTLE_RESET;
	logic [LONG_W-1:0]   long_lim   = LONG_RESET;
	phase_t              press_ph   = PH_IDLE;
	logic [LONG_W-1:0]   tick_cnt   = '0;
	press_event_t        held_kind  = EV_NONE;
	logic [COUNT_W-1:0]  bcd_now    = '0;

	logic         button_q[$];
	tick_result_t pending_results[$];

	bit calm;
	int err_cnt;
	int n_checked;
	int n_short;
	int n_long;
	int n_settings;

	function automatic press_event_t finish_press();
		press_event_t kind;
		logic [3:0]   dig;
		kind = held_kind;
		if (kind == EV_SHORT) begin
			for (int i = 0; i < CNT_DIGITS; i++) begin
				dig = bcd_now[4*i +: 4];
				bcd_now[4*i +: 4] = 4'd0;
				if (dig < 4'd9) begin
					bcd_now[4*i +: 4] = dig + 4'd1;
					break;
				end
			end
		end else if (kind == EV_LONG) begin
			bcd_now = '0;
		end
		held_kind = EV_NONE;
		tick_cnt  = '0;
		press_ph  = PH_IDLE;
		return kind;
	endfunction

	function automatic press_event_t close_press(input press_event_t kind);
		held_kind = kind;
		tick_cnt  = '0;
		if (settle_lim == 0)
			return finish_press();
		press_ph = PH_SETTLE_OUT;
		return EV_NONE;
	endfunction

	function automatic void track_sample(input logic pressed);
		press_event_t ev;
		ev = EV_NONE;
		case (press_ph)
			PH_IDLE: begin
				if (pressed) begin
					tick_cnt = '0;
					press_ph = (settle_lim == 0) ? PH_HOLD : PH_SETTLE_IN;
				end
			end
			PH_SETTLE_IN: begin
				tick_cnt = tick_cnt + 1'b1;
				if (tick_cnt >= settle_lim) begin
					tick_cnt = '0;
					press_ph = PH_HOLD;
				end
			end
			PH_HOLD: begin
				if (!pressed) begin
					ev = close_press(EV_SHORT);
				end else begin
					tick_cnt = tick_cnt + 1'b1;
					if (tick_cnt >= long_lim) begin
						tick_cnt = '0;
						press_ph = PH_WAIT_RELEASE;
					end
				end
			end
			PH_WAIT_RELEASE: begin
				if (!pressed)
					ev = close_press(EV_LONG);
			end
			PH_SETTLE_OUT: begin
				tick_cnt = tick_cnt + 1'b1;
				if (tick_cnt >= settle_lim)
					ev = finish_press();
			end
			default: begin
				press_ph  = PH_IDLE;
				tick_cnt  = '0;
				held_kind = EV_NONE;
			end
		endcase
		pending_results.push_back('{ev: ev, count: bcd_now});
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("button_press_decimal_counter_unit_tb: FAIL");
		$finish;
	end

	// Sample driver.
	int drv_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_if.valid      <= 1'b0;
			sample_if.button_low <= 1'b0;
			drv_gap              <= 0;
		end else begin
			if (sample_if.valid && sample_if.ready)
				track_sample(sample_if.button_low);
			if (!sample_if.valid || sample_if.ready) begin
				if (drv_gap != 0) begin
					sample_if.valid <= 1'b0;
					drv_gap         <= drv_gap - 1;
				end else if (!calm && $urandom_range(0, 15) == 0) begin
					sample_if.valid <= 1'b0;
					drv_gap         <= $urandom_range(0, 7);
				end else if (button_q.size() != 0) begin
					sample_if.valid      <= 1'b1;
					sample_if.button_low <= button_q.pop_front();
				end else begin
					sample_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stalls.
	int rdy_gap;
	int hold_left;
	bit hold_done;
	tick_result_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			rdy_gap         <= 0;
			hold_left       <= 0;
			hold_done       <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (pending_results.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result transaction: event %0d count %h",
							result_if.press_event, result_if.bcd_count);
				end else begin
					want = pending_results.pop_front();
					if (result_if.press_event !== want.ev ||
						result_if.bcd_count !== want.count) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("result %0d: expected event %0d count %h, got event %0d count %h",
								n_checked, want.ev, want.count,
								result_if.press_event, result_if.bcd_count);
					end
					if (want.ev == EV_SHORT)
						n_short++;
					else if (want.ev == EV_LONG)
						n_long++;
					n_checked++;
				end
			end
			if (hold_left != 0) begin
				result_if.ready <= 1'b0;
				hold_left       <= hold_left - 1;
			end else if (!hold_done && n_checked >= 250) begin
				result_if.ready <= 1'b0;
				hold_left       <= 63;
				hold_done       <= 1'b1;
			end else if (rdy_gap != 0) begin
				result_if.ready <= 1'b0;
				rdy_gap         <= rdy_gap - 1;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				result_if.ready <= 1'b0;
				rdy_gap         <= $urandom_range(0, 7);
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	task automatic write_cfg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SETTLE)
			settle_lim = val[SETTLE_W-1:0];
		else
			long_lim = val;
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (button_q.size() != 0 || sample_if.valid || pending_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int unsigned s;
		int unsigned l;
		int unsigned leff;
		int unsigned budget;
		int unsigned hold;
		int unsigned len;

		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_SETTLE;
		cfg_data             = '0;
		sample_if.valid      = 1'b0;
		sample_if.button_low = 1'b0;
		result_if.ready      = 1'b0;
		calm                 = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset limits: a plain short press, then a release right after the first settle.
		button_q = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
			1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
		drain();
		n_settings++;

		// Zero settle and zero long limit.
		write_cfg(CFG_SETTLE, 10'h300);
		write_cfg(CFG_LONG, '0);
		button_q = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		drain();
		n_settings++;

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin s = 0;   l = 1;    budget = 80;  end
				1: begin s = 1;   l = 4;    budget = 80;  end
				2: begin s = 3;   l = 12;   budget = 80;  end
				3: begin s = 0;   l = 0;    budget = 80;  end
				4: begin s = 5;   l = 30;   budget = 80;  end
				5: begin s = 2;   l = 200;  budget = 200; end
				6: begin s = 255; l = 1;    budget = 300; end
				default: begin s = 0; l = 1023; budget = 100; end
			endcase
			write_cfg(CFG_SETTLE, {2'($urandom_range(0, 3)), 8'(s)});
			write_cfg(CFG_LONG, 10'(l));
			if (p == 7)
				calm = 1'b1;
			leff = (l == 0) ? 1 : l;
			while (button_q.size() < budget) begin
				if ($urandom_range(0, 7) == 0) begin
					len = $urandom_range(1, 6);
					repeat (len) button_q.push_back($urandom_range(0, 1) != 0);
				end else begin
					if (leff <= 250 && $urandom_range(0, 2) == 0)
						hold = leff + $urandom_range(0, 3);
					else
						hold = $urandom_range(0, (leff > 20) ? 20 : leff - 1);
					button_q.push_back(1'b1);
					repeat (s) button_q.push_back($urandom_range(0, 1) != 0);
					repeat (hold) button_q.push_back(1'b1);
					button_q.push_back(1'b0);
					repeat (s) button_q.push_back($urandom_range(0, 1) != 0);
					repeat ($urandom_range(0, 3)) button_q.push_back(1'b0);
				end
			end
			drain();
			n_settings++;
		end

		repeat (8) @(posedge clk);
		$display("checked %0d result transactions over %0d limit settings", n_checked, n_settings);
		$display("completed presses seen: %0d short, %0d long; mismatches: %0d",
			n_short, n_long, err_cnt);
		if (err_cnt == 0)
			$display("button_press_decimal_counter_unit_tb: PASS");
		else
			$display("button_press_decimal_counter_unit_tb: FAIL");
		$finish;
	end

endmodule
